// ----- rtl/lfsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsf_pkg
// Shared constants and types for the largest free square finder.
// ----------------------------------------------------------------------------
package lfsf_pkg;

	localparam int CHAR_W       = 8;
	localparam int ROW_WIDTH_W  = 11;
	localparam int SIZE_OUT_W   = 11;
	localparam int POS_OUT_W    = 10;
	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	localparam logic [CHAR_W-1:0]      FREE_CHAR     = 8'd46;
	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd1024;

	// Handshake between the cell stage and the best-square tracker
	typedef struct packed {
		logic advance;
		logic last;
	} best_ctl_t;

endpackage

// ----- rtl/lfsf_best.sv -----
// ----------------------------------------------------------------------------
// lfsf_best
// Tracks the first strictly largest square of the current map.
// ----------------------------------------------------------------------------
module lfsf_best #(
	parameter int SIZE_W = 11,
	parameter int ROW_W  = 10,
	parameter int COL_W  = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfsf_pkg::best_ctl_t ctl,
	input  logic [SIZE_W-1:0]   size,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	output logic [SIZE_W-1:0]   best_size,
	output logic [ROW_W-1:0]    best_row,
	output logic [COL_W-1:0]    best_col
);
	import lfsf_pkg::*;

	logic [SIZE_W-1:0] best_size_q;
	logic [ROW_W-1:0]  best_row_q;
	logic [COL_W-1:0]  best_col_q;
	logic              first_q;
	logic              take;

	// First cell of a map always wins; afterwards only a strictly larger one
	assign take      = first_q || (size > best_size_q);
	assign best_size = take ? size : best_size_q;
	assign best_row  = take ? row  : best_row_q;
	assign best_col  = take ? col  : best_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			first_q     <= 1'b1;
		end else if (ctl.advance) begin
			if (ctl.last) begin
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
				first_q     <= 1'b1;
			end else begin
				best_size_q <= best_size;
				best_row_q  <= best_row;
				best_col_q  <= best_col;
				first_q     <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/largest_free_square_finder_core.sv -----
// ----------------------------------------------------------------------------
// largest_free_square_finder_core
// Streams map cells in raster order and reports the largest free square.
// ----------------------------------------------------------------------------
// Output: registered when the end-of-map beat leaves the update stage.
// Throughput: one cell per cycle; the line memory is read at accept and written
//   on advance through a separate write port, with same-entry forwarding.
//   The input holds only while a finished map waits behind an untaken result.
// Reset: arst_n clears counters, tracker and output valid; the line memory is
//   left unset and the first row of a map never uses it.
module largest_free_square_finder_core #(
	parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [lfsf_pkg::ROW_WIDTH_W-1:0]   cfg_wdata,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lfsf_pkg::CHAR_W-1:0]        cell_char,
	input  logic                               end_of_map,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lfsf_pkg::SIZE_OUT_W-1:0]    square_size,
	output logic [lfsf_pkg::POS_OUT_W-1:0]     end_row,
	output logic [lfsf_pkg::POS_OUT_W-1:0]     end_col,
	output logic                               rows_overflow
);
	import lfsf_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int SIZE_W = $clog2(MAX_COLS + 1);
	// compare width wide enough for both the register and MAX_COLS
	localparam int CMP_W  = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;

	// Configuration
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [CMP_W-1:0]       width_ext;
	logic [CMP_W-1:0]       eff_width;

	// Scan position, advanced at accept
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             ovf_q;
	logic             row_end;
	logic             row_last;
	logic             ovf_nxt;
	logic             in_fire;

	// Update stage
	logic              s1_valid;
	logic              s1_adv;
	logic              free_s1;
	logic              last_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              row_zero_s1;
	logic              ovf_s1;
	logic              fwd_s1;
	logic [SIZE_W-1:0] fwd_data_s1;
	logic [SIZE_W-1:0] rd_data_s1;

	logic [SIZE_W-1:0] left_q;
	logic [SIZE_W-1:0] diag_q;
	logic [SIZE_W-1:0] up_val;
	logic [SIZE_W-1:0] left_val;
	logic [SIZE_W-1:0] diag_val;
	logic [SIZE_W-1:0] min_val;
	logic [SIZE_W-1:0] size_s1;

	// Line memory: sizes of the row above, one entry per column
	logic [SIZE_W-1:0] line_mem [MAX_COLS];

	// Best-square tracker
	best_ctl_t         best_ctl;
	logic [SIZE_W-1:0] best_size;
	logic [ROW_W-1:0]  best_row;
	logic [COL_W-1:0]  best_col;

	// Output register
	logic                  out_valid_q;
	logic [SIZE_OUT_W-1:0] square_size_q;
	logic [POS_OUT_W-1:0]  end_row_q;
	logic [POS_OUT_W-1:0]  end_col_q;
	logic                  rows_overflow_q;

	// ------------------------------------------------------------------
	// Configuration register; zero acts as one, oversize clamps to MAX_COLS
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	always_comb begin
		width_ext = CMP_W'(row_width_q);
		if (width_ext == '0) begin
			eff_width = CMP_W'(1);
		end else if (width_ext > CMP_W'(MAX_COLS)) begin
			eff_width = CMP_W'(MAX_COLS);
		end else begin
			eff_width = width_ext;
		end
	end

	// ------------------------------------------------------------------
	// Accept side: the scan position depends only on the width, so it
	// advances as the beat is taken, and the memory read is issued at once
	// ------------------------------------------------------------------
	// Hold the last-cell beat in the update stage while a result is still
	// waiting; every other beat moves on without regard to the output side.
	assign s1_adv   = s1_valid && !(last_s1 && out_valid_q && !out_ready);
	assign in_ready = !s1_valid || s1_adv;
	assign in_fire  = in_valid && in_ready;

	assign row_end  = (CMP_W'(col_q) + CMP_W'(1)) >= eff_width;
	assign row_last = (row_q == ROW_W'(MAX_ROWS - 1));
	assign ovf_nxt  = ovf_q || (row_end && row_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ovf_q <= 1'b0;
		end else if (in_fire) begin
			if (end_of_map) begin
				// drop all scan state for the next map
				col_q <= '0;
				row_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				col_q <= row_end ? '0 : col_q + COL_W'(1);
				// past the last supported row, keep reusing that row index
				if (row_end && !row_last) begin
					row_q <= row_q + ROW_W'(1);
				end
				ovf_q <= ovf_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_fire) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			free_s1     <= (cell_char == FREE_CHAR);
			last_s1     <= end_of_map;
			col_s1      <= col_q;
			row_s1      <= row_q;
			row_zero_s1 <= (row_q == '0);
			ovf_s1      <= ovf_nxt;
			// The entry written by the beat leaving the update stage on this
			// edge is the one being read (narrow rows): forward its size.
			fwd_s1      <= s1_valid && (col_s1 == col_q);
			fwd_data_s1 <= size_s1;
		end
	end

	// Line memory, one read and one write port: read on accept, write back on advance
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_data_s1 <= line_mem[col_q];
		end
		if (s1_adv) begin
			line_mem[col_s1] <= size_s1;
		end
	end

	// ------------------------------------------------------------------
	// Update stage: one min of three, an increment and the best compare
	// ------------------------------------------------------------------
	always_comb begin
		up_val   = row_zero_s1 ? '0 : (fwd_s1 ? fwd_data_s1 : rd_data_s1);
		// column zero has no left or diagonal neighbour
		left_val = (col_s1 == '0) ? '0 : left_q;
		diag_val = (col_s1 == '0) ? '0 : diag_q;
		min_val  = up_val;
		if (left_val < min_val) begin
			min_val = left_val;
		end
		if (diag_val < min_val) begin
			min_val = diag_val;
		end
		size_s1 = free_s1 ? min_val + SIZE_W'(1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
		end else if (s1_adv) begin
			left_q <= size_s1;
			diag_q <= up_val;
		end
	end

	assign best_ctl.advance = s1_adv;
	assign best_ctl.last    = last_s1;

	lfsf_best #(
		.SIZE_W (SIZE_W),
		.ROW_W  (ROW_W),
		.COL_W  (COL_W)
	) u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (best_ctl),
		.size      (size_s1),
		.row       (row_s1),
		.col       (col_s1),
		.best_size (best_size),
		.best_row  (best_row),
		.best_col  (best_col)
	);

	// ------------------------------------------------------------------
	// Output register: load on the last cell, hold until the beat is taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			square_size_q   <= SIZE_OUT_W'(best_size);
			end_row_q       <= POS_OUT_W'(best_row);
			end_col_q       <= POS_OUT_W'(best_col);
			rows_overflow_q <= ovf_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign square_size   = square_size_q;
	assign end_row       = end_row_q;
	assign end_col       = end_col_q;
	assign rows_overflow = rows_overflow_q;

endmodule

// ----- rtl/lfsf_checker.sv -----
// ----------------------------------------------------------------------------
// lfsf_checker
// Port-level checks for the largest free square finder.
// ----------------------------------------------------------------------------
module lfsf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             end_of_map,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [lfsf_pkg::SIZE_OUT_W-1:0]  square_size,
	input logic [lfsf_pkg::POS_OUT_W-1:0]   end_row,
	input logic [lfsf_pkg::POS_OUT_W-1:0]   end_col
);
	import lfsf_pkg::*;

	// A result beat stays offered until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	// The input side only stalls behind a waiting, untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	// A fresh result follows an accepted end-of-map beat
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && end_of_map, 2))
		else $error("result without a matching end-of-map beat");

	// A map without free cells reports the first cell as the position
	a_empty_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (square_size == '0) |-> (end_row == '0) && (end_col == '0))
		else $error("empty result carries a nonzero position");

endmodule

bind largest_free_square_finder_core lfsf_checker u_lfsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.end_of_map  (end_of_map),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.square_size (square_size),
	.end_row     (end_row),
	.end_col     (end_col)
);
